@@ rtl/psrl_pkg.sv @@
// Package for the per-source rate limiter: widths, codes, state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psrl_pkg;
    localparam int ENTRIES = 64;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam int TS_W = 48;
    localparam int CFG_IDX_W = 2;
    localparam int MS_PER_S = 1000;
    localparam int S_PER_HOUR = 3600;
    localparam int DIV_W = 44;

    localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_INT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PENALTY = 2'd3;

    localparam logic [2:0] OUT_NEW = 3'd0;
    localparam logic [2:0] OUT_NEW_EVICT = 3'd1;
    localparam logic [2:0] OUT_ALLOWED = 3'd2;
    localparam logic [2:0] OUT_EXPIRED = 3'd3;
    localparam logic [2:0] OUT_IN_PENALTY = 3'd4;
    localparam logic [2:0] OUT_PENALIZED = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_SCAN_WAIT, ST_DECIDE, ST_SEC_MUL, ST_RATE,
        ST_DIV_RATE, ST_FINISH, ST_WRITE, ST_OUT
    } t_state;

    typedef struct packed {
        logic       start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

@@ rtl/psrl_if.sv @@
// Handshake interfaces for the rate limiter channels.
// Depends on psrl_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface psrl_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [47:0] now_ms;
    modport source (output valid, address_high, address_low, now_ms, input ready);
    modport sink (input valid, address_high, address_low, now_ms, output ready);
endinterface

interface psrl_rsp_if;
    logic       valid;
    logic       ready;
    logic       allow;
    logic [2:0] outcome;
    modport source (output valid, allow, outcome, input ready);
    modport sink (input valid, allow, outcome, output ready);
endinterface

interface psrl_cfg_if;
    logic        valid;
    logic        ready;
    logic [psrl_pkg::CFG_IDX_W-1:0] index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/psrl_divider.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on psrl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psrl_divider (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire psrl_pkg::t_div_req i_req,
    output psrl_pkg::t_div_rsp o_rsp
);
    localparam int W = psrl_pkg::DIV_W;
    logic [W-1:0] r_quo, n_quo;
    logic [W-1:0] r_rem, n_rem;
    logic [W-1:0] r_den;
    logic [$clog2(W+1)-1:0] r_cnt, n_cnt;
    logic r_busy, n_busy, r_done, n_done;
    logic [W:0] w_trial;

    always_comb begin
        w_trial = {r_rem, r_quo[W-1]} - {1'b0, r_den};
        n_quo = r_quo;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo = i_req.dividend;
            n_rem = '0;
            n_cnt = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial[W]) begin
                n_rem = {r_rem[W-2:0], r_quo[W-1]};
                n_quo = {r_quo[W-2:0], 1'b0};
            end else begin
                n_rem = w_trial[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == ($clog2(W+1))'(W-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_req.start) r_den <= i_req.divisor;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

@@ rtl/per_source_rate_limiter.sv @@
// Per-source rate limiter: top level with tracker table and sequencer.
// Depends on psrl_pkg, the interfaces in psrl_if and psrl_divider.
//
// Usage: a request transfer on i_req carries a 128-bit source address and
// a millisecond timestamp. One response transfer on o_rsp follows per
// request, with allow and an outcome code. Configuration writes on i_cfg
// (index 0 rate limit, 1 min_count, 2 reset_interval_s, 3 penalty_s) are
// taken at any time but should only be made while the block is idle.
// One request is handled at a time. The table scan reads one entry per
// cycle from the tracker memories, then passes a wait and a decision state.
// A hit that needs a rate forms whole seconds by reciprocal multiplication,
// divides in the serial divider, then finishes and writes back. Misses and
// hits inside a penalty go from the decision straight to write-back, and
// hits below min_count skip the rate and go straight to finish. The next
// request can be taken in the cycle after the response transfer. Reset
// clears the valid bits and loads the default configuration. While the
// receiver stalls the response register holds and no new request is
// taken.
`timescale 1ns / 1ps
`default_nettype none
module per_source_rate_limiter (
    input wire logic i_clk,
    input wire logic i_rst_n,
    psrl_req_if.sink i_req,
    psrl_rsp_if.source o_rsp,
    psrl_cfg_if.sink i_cfg
);
    localparam int IW = psrl_pkg::IDX_W;
    localparam int CW = psrl_pkg::CNT_W;
    localparam int TW = psrl_pkg::TS_W;
    localparam int DW = psrl_pkg::DIV_W;
    localparam logic [TW-1:0] TS_MAX = '1;
    localparam logic [45:0] RECIP_125 = 46'd36028797018964;

    psrl_pkg::t_state r_state, n_state;
    logic [31:0] r_rate_limit, r_min_count;
    logic [15:0] r_reset_int, r_penalty;

    logic [63:0] m_kh [psrl_pkg::ENTRIES];
    logic [63:0] m_kl [psrl_pkg::ENTRIES];
    logic [31:0] m_cnt [psrl_pkg::ENTRIES];
    logic [TW-1:0] m_first [psrl_pkg::ENTRIES];
    logic [TW-1:0] m_last [psrl_pkg::ENTRIES];
    logic [TW-1:0] m_pen [psrl_pkg::ENTRIES];
    logic [psrl_pkg::ENTRIES-1:0] r_valid, r_pact;

    logic [63:0] r_kh, r_kl;
    logic [TW-1:0] r_now;
    logic [CW-1:0] r_ptr;
    logic [IW-1:0] r_rd_idx;
    logic r_rd_ok;
    logic [63:0] r_rd_kh, r_rd_kl;
    logic [31:0] r_rd_cnt;
    logic [TW-1:0] r_rd_first, r_rd_last, r_rd_pen;

    logic r_hit, r_free_f, r_old_f;
    logic [IW-1:0] r_hit_i, r_free_i, r_old_i;
    logic [TW-1:0] r_old_ts;
    logic [31:0] r_cnt;
    logic [TW-1:0] r_first, r_pen;
    logic [DW-1:0] r_prod;
    logic [90:0] r_acc;
    logic [1:0] r_mstep;
    logic r_allow;
    logic [2:0] r_outcome;
    logic r_wr_new, r_wr_hit, r_set_pen, r_clr_pen, r_inval;
    logic r_rsp_valid;

    psrl_pkg::t_div_req w_div_req;
    psrl_pkg::t_div_rsp w_div_rsp;
    logic [TW-1:0] w_elapsed;
    logic [TW:0] w_pen_end;
    logic [TW-1:0] w_pen_sat;
    logic [14:0] w_slice;
    logic [60:0] w_part;
    logic [DW-1:0] w_secs;

    psrl_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_div_req), .o_rsp(w_div_rsp));

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == psrl_pkg::ST_IDLE);
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.allow = r_allow;
    assign o_rsp.outcome = r_outcome;

    assign w_elapsed = (r_now < r_first) ? '0 : r_now - r_first;
    assign w_pen_end = {1'b0, r_now} + (TW+1)'(r_penalty * 32'd1000);
    assign w_pen_sat = w_pen_end[TW] ? TS_MAX : w_pen_end[TW-1:0];

    // Whole seconds are (elapsed / 8) / 125. The reciprocal of 125 scaled by
    // 2^52 gives the exact floor for any 45-bit operand; it is applied one
    // 15-bit slice per cycle, most significant slice first.
    always_comb begin
        case (r_mstep)
            2'd0: w_slice = w_elapsed[47:33];
            2'd1: w_slice = w_elapsed[32:18];
            2'd2: w_slice = w_elapsed[17:3];
            default: w_slice = '0;
        endcase
    end
    assign w_part = w_slice * RECIP_125;
    assign w_secs = (r_acc[90:52] == '0) ? DW'(1) : DW'(r_acc[90:52]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psrl_pkg::ST_IDLE: if (i_req.valid) n_state = psrl_pkg::ST_SCAN;
            psrl_pkg::ST_SCAN:
                if (r_ptr == CW'(psrl_pkg::ENTRIES)) n_state = psrl_pkg::ST_SCAN_WAIT;
            psrl_pkg::ST_SCAN_WAIT: n_state = psrl_pkg::ST_DECIDE;
            psrl_pkg::ST_DECIDE: begin
                if (!r_hit) n_state = psrl_pkg::ST_WRITE;
                else if (r_pact[r_hit_i] && r_pen > r_now) n_state = psrl_pkg::ST_WRITE;
                else if (r_cnt < r_min_count) n_state = psrl_pkg::ST_FINISH;
                else n_state = psrl_pkg::ST_SEC_MUL;
            end
            psrl_pkg::ST_SEC_MUL: if (r_mstep == 2'd2) n_state = psrl_pkg::ST_RATE;
            psrl_pkg::ST_RATE: n_state = psrl_pkg::ST_DIV_RATE;
            psrl_pkg::ST_DIV_RATE: if (w_div_rsp.done) n_state = psrl_pkg::ST_FINISH;
            psrl_pkg::ST_FINISH: n_state = psrl_pkg::ST_WRITE;
            psrl_pkg::ST_WRITE: n_state = psrl_pkg::ST_OUT;
            psrl_pkg::ST_OUT: if (o_rsp.ready) n_state = psrl_pkg::ST_IDLE;
            default: n_state = psrl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_div_req.start = (r_state == psrl_pkg::ST_RATE);
        w_div_req.dividend = r_prod;
        w_div_req.divisor = w_secs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psrl_pkg::ST_IDLE;
            r_rate_limit <= 32'd3600;
            r_min_count <= 32'd60;
            r_reset_int <= 16'd120;
            r_penalty <= 16'd60;
            r_valid <= '0;
            r_pact <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    psrl_pkg::REG_RATE_LIMIT: r_rate_limit <= i_cfg.data;
                    psrl_pkg::REG_MIN_COUNT: r_min_count <= i_cfg.data;
                    psrl_pkg::REG_RESET_INT: r_reset_int <= i_cfg.data[15:0];
                    psrl_pkg::REG_PENALTY: r_penalty <= i_cfg.data[15:0];
                    default: r_penalty <= r_penalty;
                endcase
            end
            if (r_state == psrl_pkg::ST_WRITE) begin
                r_rsp_valid <= 1'b1;
                if (r_wr_new) begin
                    r_valid[r_hit_i] <= 1'b1;
                    r_pact[r_hit_i] <= 1'b0;
                end
                if (r_set_pen) r_pact[r_hit_i] <= 1'b1;
                if (r_clr_pen) r_pact[r_hit_i] <= 1'b0;
                if (r_inval) r_valid[r_hit_i] <= 1'b0;
            end
            if (r_state == psrl_pkg::ST_OUT && o_rsp.ready) r_rsp_valid <= 1'b0;
        end

        // Scan: address one entry per cycle, compare the registered read.
        if (r_state == psrl_pkg::ST_IDLE) begin
            r_kh <= i_req.address_high;
            r_kl <= i_req.address_low;
            r_now <= i_req.now_ms;
            r_ptr <= '0;
            r_rd_ok <= 1'b0;
            r_hit <= 1'b0;
            r_free_f <= 1'b0;
            r_old_f <= 1'b0;
        end
        if (r_state == psrl_pkg::ST_SCAN) begin
            r_ptr <= r_ptr + 1'b1;
            r_rd_idx <= r_ptr[IW-1:0];
            r_rd_ok <= (r_ptr != CW'(psrl_pkg::ENTRIES));
            r_rd_kh <= m_kh[r_ptr[IW-1:0]];
            r_rd_kl <= m_kl[r_ptr[IW-1:0]];
            r_rd_cnt <= m_cnt[r_ptr[IW-1:0]];
            r_rd_first <= m_first[r_ptr[IW-1:0]];
            r_rd_last <= m_last[r_ptr[IW-1:0]];
            r_rd_pen <= m_pen[r_ptr[IW-1:0]];
        end
        if ((r_state == psrl_pkg::ST_SCAN || r_state == psrl_pkg::ST_SCAN_WAIT) && r_rd_ok) begin
            if (r_state == psrl_pkg::ST_SCAN_WAIT) r_rd_ok <= 1'b0;
            if (r_valid[r_rd_idx]) begin
                if (!r_hit && r_rd_kh == r_kh && r_rd_kl == r_kl) begin
                    r_hit <= 1'b1;
                    r_hit_i <= r_rd_idx;
                    r_cnt <= (r_rd_cnt == 32'hFFFF_FFFF) ? r_rd_cnt : r_rd_cnt + 1'b1;
                    r_first <= r_rd_first;
                    r_pen <= r_rd_pen;
                end
                if (!r_old_f || r_rd_last < r_old_ts) begin
                    r_old_f <= 1'b1;
                    r_old_i <= r_rd_idx;
                    r_old_ts <= r_rd_last;
                end
            end else if (!r_free_f) begin
                r_free_f <= 1'b1;
                r_free_i <= r_rd_idx;
            end
        end

        if (r_state == psrl_pkg::ST_DECIDE) begin
            r_wr_new <= !r_hit;
            r_wr_hit <= r_hit;
            r_set_pen <= 1'b0;
            r_clr_pen <= 1'b0;
            r_inval <= 1'b0;
            r_prod <= '0;
            r_acc <= '0;
            r_mstep <= '0;
            if (!r_hit) begin
                r_hit_i <= r_free_f ? r_free_i : (r_old_f ? r_old_i : '0);
                r_allow <= 1'b1;
                r_outcome <= r_free_f ? psrl_pkg::OUT_NEW : psrl_pkg::OUT_NEW_EVICT;
            end else if (r_pact[r_hit_i] && r_pen > r_now) begin
                r_allow <= 1'b0;
                r_outcome <= psrl_pkg::OUT_IN_PENALTY;
            end
        end
        if (r_state == psrl_pkg::ST_SEC_MUL) begin
            r_acc <= {r_acc[75:0], 15'd0} + {30'd0, w_part};
            r_mstep <= r_mstep + 1'b1;
            r_prod <= DW'(r_cnt * 44'd3600);
        end
        if (r_state == psrl_pkg::ST_DIV_RATE && w_div_rsp.done) r_prod <= w_div_rsp.quotient;
        if (r_state == psrl_pkg::ST_FINISH) begin
            // r_prod holds the hourly rate, zero below min_count.
            if (r_prod >= DW'(r_rate_limit)) begin
                r_set_pen <= 1'b1;
                r_pen <= w_pen_sat;
                r_allow <= 1'b0;
                r_outcome <= psrl_pkg::OUT_PENALIZED;
            end else begin
                r_clr_pen <= 1'b1;
                r_allow <= 1'b1;
                if (w_elapsed > TW'(r_reset_int * 32'd1000)) begin
                    r_inval <= 1'b1;
                    r_outcome <= psrl_pkg::OUT_EXPIRED;
                end else begin
                    r_outcome <= psrl_pkg::OUT_ALLOWED;
                end
            end
        end

        if (r_state == psrl_pkg::ST_WRITE) begin
            if (r_wr_new) begin
                m_kh[r_hit_i] <= r_kh;
                m_kl[r_hit_i] <= r_kl;
                m_cnt[r_hit_i] <= 32'd1;
                m_first[r_hit_i] <= r_now;
                m_last[r_hit_i] <= r_now;
                m_pen[r_hit_i] <= r_now;
            end
            if (r_wr_hit) begin
                m_cnt[r_hit_i] <= r_cnt;
                m_last[r_hit_i] <= r_now;
                if (r_set_pen) m_pen[r_hit_i] <= r_pen;
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/psrl_checker.sv @@
// Port-level checks for the rate limiter, bound to the top level.
// Depends on psrl_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module psrl_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic rsp_allow,
    input wire logic [2:0] rsp_outcome
);
    a_no_req_while_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready) else $error("request taken while response pending");
    a_req_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_valid && req_ready) |=> !req_ready) else $error("ready after transfer");
    a_allow_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> (rsp_allow == (rsp_outcome != psrl_pkg::OUT_IN_PENALTY &&
                       rsp_outcome != psrl_pkg::OUT_PENALIZED))) else $error("allow mismatch");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_outcome)))
        else $error("response dropped");
endmodule

bind per_source_rate_limiter psrl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready),
    .rsp_allow(o_rsp.allow), .rsp_outcome(o_rsp.outcome)
);
`default_nettype wire

@@ tb/per_source_rate_limiter_chk.sv @@
// Checker for the per-source rate limiter: watches the request, response and
// configuration channels, predicts each response and compares it.
// Depends on psrl_pkg and the interfaces in psrl_if.
`timescale 1ns / 1ps
`default_nettype none
module per_source_rate_limiter_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    psrl_req_if i_req,
    psrl_rsp_if i_rsp,
    psrl_cfg_if i_cfg,
    output int o_fail_count,
    output int o_pending
);
    typedef struct packed {
        logic       allow;
        logic [2:0] outcome;
    } t_verdict;

    localparam logic [47:0] TS_MAX = '1;

    logic [31:0] rate_limit_q, min_count_q;
    logic [15:0] reset_int_q, penalty_q;
    logic [63:0] tag_hi [psrl_pkg::ENTRIES];
    logic [63:0] tag_lo [psrl_pkg::ENTRIES];
    logic        live [psrl_pkg::ENTRIES];
    logic [31:0] hits [psrl_pkg::ENTRIES];
    logic [47:0] first_ts [psrl_pkg::ENTRIES];
    logic [47:0] last_ts [psrl_pkg::ENTRIES];
    logic [47:0] block_until [psrl_pkg::ENTRIES];
    logic        blocked [psrl_pkg::ENTRIES];
    t_verdict    verdict_q [$];

    function automatic logic [47:0] age_ms(int e);
        return (last_ts[e] < first_ts[e]) ? 48'd0 : last_ts[e] - first_ts[e];
    endfunction

    function automatic t_verdict judge_request(logic [63:0] kh, logic [63:0] kl,
                                               logic [47:0] now);
        int hit, free_slot, oldest, slot;
        logic [63:0] secs, rate, until_ms;
        t_verdict v;
        hit = -1; free_slot = -1; oldest = -1;
        for (int i = 0; i < psrl_pkg::ENTRIES; i++) begin
            if (live[i]) begin
                if (hit < 0 && tag_hi[i] == kh && tag_lo[i] == kl) hit = i;
                if (oldest < 0 || last_ts[i] < last_ts[oldest]) oldest = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (hit < 0) begin
            slot = (free_slot >= 0) ? free_slot : oldest;
            tag_hi[slot] = kh; tag_lo[slot] = kl; live[slot] = 1'b1;
            hits[slot] = 32'd1; first_ts[slot] = now; last_ts[slot] = now;
            block_until[slot] = now; blocked[slot] = 1'b0;
            v.allow = 1'b1;
            v.outcome = (free_slot >= 0) ? psrl_pkg::OUT_NEW : psrl_pkg::OUT_NEW_EVICT;
            return v;
        end
        if (hits[hit] != '1) hits[hit]++;
        last_ts[hit] = now;
        if (blocked[hit] && block_until[hit] > now) begin
            v.allow = 1'b0; v.outcome = psrl_pkg::OUT_IN_PENALTY;
            return v;
        end
        if (hits[hit] < min_count_q) begin
            rate = 0;
        end else begin
            secs = 64'(age_ms(hit)) / 64'd1000;
            if (secs < 1) secs = 1;
            rate = (64'(hits[hit]) * 64'd3600) / secs;
        end
        if (rate >= 64'(rate_limit_q)) begin
            until_ms = 64'(now) + 64'(penalty_q) * 64'd1000;
            block_until[hit] = (until_ms > 64'(TS_MAX)) ? TS_MAX : until_ms[47:0];
            blocked[hit] = 1'b1;
            v.allow = 1'b0; v.outcome = psrl_pkg::OUT_PENALIZED;
            return v;
        end
        blocked[hit] = 1'b0;
        if (64'(age_ms(hit)) > 64'(reset_int_q) * 64'd1000) begin
            live[hit] = 1'b0;
            v.allow = 1'b1; v.outcome = psrl_pkg::OUT_EXPIRED;
            return v;
        end
        v.allow = 1'b1; v.outcome = psrl_pkg::OUT_ALLOWED;
        return v;
    endfunction

    assign o_pending = verdict_q.size();

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            rate_limit_q <= 32'd3600; min_count_q <= 32'd60;
            reset_int_q <= 16'd120; penalty_q <= 16'd60;
            for (int i = 0; i < psrl_pkg::ENTRIES; i++) begin
                live[i] = 1'b0; blocked[i] = 1'b0;
            end
            verdict_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    psrl_pkg::REG_RATE_LIMIT: rate_limit_q <= i_cfg.data;
                    psrl_pkg::REG_MIN_COUNT:  min_count_q <= i_cfg.data;
                    psrl_pkg::REG_RESET_INT:  reset_int_q <= i_cfg.data[15:0];
                    psrl_pkg::REG_PENALTY:    penalty_q <= i_cfg.data[15:0];
                    default: ;
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (verdict_q.size() == 0) begin
                    $error("response transfer with no request outstanding");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_rsp.allow !== want.allow) begin
                        $error("allow: expected %0d, got %0d", want.allow, i_rsp.allow);
                        o_fail_count <= o_fail_count + 1;
                    end else if (i_rsp.outcome !== want.outcome) begin
                        $error("outcome: expected %0d, got %0d", want.outcome,
                               i_rsp.outcome);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                verdict_q.push_back(judge_request(i_req.address_high,
                                                  i_req.address_low, i_req.now_ms));
        end
    end
endmodule
`default_nettype wire

@@ tb/per_source_rate_limiter_tb.sv @@
// Top of the rate limiter testbench: clock, reset, stimulus and verdict.
// Depends on psrl_pkg, psrl_if, the block and per_source_rate_limiter_chk.
`timescale 1ns / 1ps
`default_nettype none
module per_source_rate_limiter_tb;
    localparam int WATCHDOG = 20000;
    localparam int SETTLE = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, idle_cycles;
    logic [47:0] clock_ms;
    logic [63:0] pool_hi [16];
    logic [63:0] pool_lo [16];

    psrl_req_if req_ch();
    psrl_rsp_if rsp_ch();
    psrl_cfg_if cfg_ch();

    per_source_rate_limiter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(req_ch.sink), .o_rsp(rsp_ch.source), .i_cfg(cfg_ch.sink)
    );

    per_source_rate_limiter_chk checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch), .i_rsp(rsp_ch),
        .i_cfg(cfg_ch), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver stalls at random in some stretches, with long stall-free stretches between.
    initial begin
        int phase;
        rsp_ch.ready = 1'b0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (phase % 2000 < 600) rsp_ch.ready = 1'b1;
            else rsp_ch.ready = ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_request(logic [63:0] kh, logic [63:0] kl, logic [47:0] now);
        req_ch.valid = 1'b1;
        req_ch.address_high = kh;
        req_ch.address_low = kl;
        req_ch.now_ms = now;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_register(logic [psrl_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_limits(logic [31:0] rate, logic [31:0] cnt, logic [15:0] rint,
                              logic [15:0] pen);
        drain();
        write_register(psrl_pkg::REG_RATE_LIMIT, rate);
        write_register(psrl_pkg::REG_MIN_COUNT, cnt);
        write_register(psrl_pkg::REG_RESET_INT, rint);
        write_register(psrl_pkg::REG_PENALTY, pen);
    endtask

    // Random traffic from a small pool of sources so that hits, penalties and
    // expiry happen; a few items use wide random addresses and wild times.
    task automatic random_burst(int count);
        int gap, sel;
        logic [63:0] kh, kl;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 30);
                repeat (gap) @(negedge i_clk);
            end
            sel = $urandom_range(0, 15);
            kh = pool_hi[sel];
            kl = pool_lo[sel];
            case ($urandom_range(0, 19))
                0: begin
                    kh = {$urandom, $urandom};
                    kl = {$urandom, $urandom};
                end
                1: clock_ms = clock_ms - $urandom_range(0, 5000);
                2: clock_ms = 48'({$urandom, $urandom});
                3: clock_ms = clock_ms + $urandom_range(100000, 400000);
                default: clock_ms = clock_ms + $urandom_range(0, 3000);
            endcase
            send_request(kh, kl, clock_ms);
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.address_high = '0;
        req_ch.address_low = '0;
        req_ch.now_ms = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = psrl_pkg::REG_RATE_LIMIT;
        cfg_ch.data = '0;
        clock_ms = 48'd1000;
        for (int i = 0; i < 16; i++) begin
            pool_hi[i] = (i < 8) ? 64'd0 : {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
        end
        pool_hi[0] = '1;
        pool_lo[0] = '1;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: new, hit, quick burst leading to penalty, in-penalty,
        // saturated penalty end, time going backwards, expiry.
        send_request(64'd0, 64'd0, 48'd0);
        send_request(64'd0, 64'd0, 48'd500);
        set_limits(32'd1, 32'd0, 16'd0, 16'hFFFF);
        send_request(64'd0, 64'd0, 48'hFFFF_FFFF_FF00);
        send_request(64'd0, 64'd0, 48'hFFFF_FFFF_FF01);
        send_request('1, '1, 48'd10);
        send_request('1, '1, 48'd5);
        set_limits('1, '1, 16'd1, 16'd0);
        send_request(64'd7, 64'd7, 48'd0);
        send_request(64'd7, 64'd7, 48'd900);
        send_request(64'd7, 64'd7, 48'd5000);
        set_limits(32'd0, 32'd0, 16'd5, 16'd2);
        send_request(64'd8, 64'd8, 48'd0);
        send_request(64'd8, 64'd8, 48'd10);
        send_request(64'd8, 64'd8, 48'd2010);
        set_limits(32'd3600, 32'd60, 16'd120, 16'd60);
        // Fill the table past capacity so that eviction happens, with ties.
        for (int i = 0; i < 66; i++)
            send_request(64'd1, 64'(i + 100), 48'(1000 + (i / 2)));

        set_limits(32'd7200, 32'd3, 16'd20, 16'd5);
        random_burst(300);
        set_limits(32'd4000, 32'd0, 16'd65535, 16'd1);
        random_burst(300);
        drain();
        set_limits(32'd100000, 32'd2, 16'd3, 16'd30);
        random_burst(280);
        drain();

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
rtl/psrl_pkg.sv
rtl/psrl_if.sv
rtl/psrl_divider.sv
rtl/per_source_rate_limiter.sv
rtl/psrl_checker.sv
tb/per_source_rate_limiter_chk.sv
tb/per_source_rate_limiter_tb.sv
